// File: rtl/gcbc_pkg.sv
// shared types and constants for the connected components block
package gcbc_pkg;

   localparam int MAX_VERTICES_DEF = 32;
   localparam int ROW_LIMIT        = 32;
   localparam int ROW_BITS         = 32;
   localparam int ROW_IDX_W        = 5;
   localparam int VC_W             = 6;
   localparam logic [VC_W-1:0] VERTEX_COUNT_RST = 6'd32;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_EDGE,
      CELL_PREP,
      CELL_ROUND,
      CELL_SHIFT,
      CELL_CLEAR
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      cell_op_type            op;
      logic [ROW_IDX_W-1:0]   pivot_idx;
      logic [ROW_IDX_W-1:0]   a_idx;
      logic [ROW_IDX_W-1:0]   b_idx;
      logic [ROW_BITS-1:0]    valid_mask;
   } cell_cmd_type;

endpackage

// File: rtl/gcbc_cell.sv
// one adjacency row cell of the ring, closure update on the row passing through
module gcbc_cell
   import gcbc_pkg::*;
#(
   parameter int ROW_INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_cmd_type         cmd,
   input  logic [ROW_BITS-1:0]  pivot_row,
   input  logic [ROW_BITS-1:0]  neighbor_row,
   output logic [ROW_BITS-1:0]  row
);

   localparam logic [ROW_IDX_W-1:0] MY_IDX = ROW_IDX_W'(ROW_INDEX);

   logic [ROW_BITS-1:0] row_ff;
   logic [ROW_BITS-1:0] row_in;
   logic [ROW_BITS-1:0] self_bit;

   assign self_bit = ROW_BITS'(1) << MY_IDX;

   always_comb begin
      row_in = row_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
            row_in = row_ff;
         end
         CELL_EDGE: begin
            if (cmd.a_idx == MY_IDX) begin
               row_in = row_in | (ROW_BITS'(1) << cmd.b_idx);
            end
            if (cmd.b_idx == MY_IDX) begin
               row_in = row_in | (ROW_BITS'(1) << cmd.a_idx);
            end
         end
         CELL_PREP: begin
            row_in = cmd.valid_mask[MY_IDX] ? ((row_ff & cmd.valid_mask) | self_bit)
                                            : '0;
         end
         CELL_ROUND: begin
            row_in = neighbor_row[cmd.pivot_idx] ? (neighbor_row | pivot_row)
                                                 : neighbor_row;
         end
         CELL_SHIFT: begin
            row_in = neighbor_row;
         end
         CELL_CLEAR: begin
            row_in = '0;
         end
         default: begin
            row_in = row_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row = row_ff;

endmodule

// File: rtl/gcbc_ctrl.sv
// sequencer: edge load, closure rounds, component scan and result register
module gcbc_ctrl
   import gcbc_pkg::*;
#(
   parameter int CELL_COUNT = ROW_LIMIT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_action,
   input  logic [VC_W-1:0]      req_vertex_a,
   input  logic [VC_W-1:0]      req_vertex_b,
   input  logic [VC_W-1:0]      active_n,
   input  logic [ROW_BITS-1:0]  head_row,
   output logic                 busy,
   output cell_cmd_type         cmd,
   output logic                 rsp_valid,
   output logic [VC_W-1:0]      rsp_component_number,
   output logic [ROW_BITS-1:0]  rsp_member_mask,
   output logic                 rsp_last_component
);

   localparam int K_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam logic [K_W-1:0] K_LAST = K_W'(CELL_COUNT - 1);

   state_type               state_ff, state_in;
   logic [K_W-1:0]          k_ff, k_in;
   logic [ROW_IDX_W-1:0]    u_ff, u_in;
   logic [ROW_BITS-1:0]     listed_ff, listed_in;
   logic [VC_W-1:0]         comp_ff, comp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VC_W-1:0]         rsp_number_ff, rsp_number_in;
   logic [ROW_BITS-1:0]     rsp_mask_ff, rsp_mask_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [ROW_BITS-1:0]     valid_mask;
   logic [ROW_BITS-1:0]     members;
   logic                    a_ok, b_ok;

   assign valid_mask = (active_n >= VC_W'(ROW_BITS)) ? '1
                     : ((ROW_BITS'(1) << active_n) - ROW_BITS'(1));
   assign members    = head_row & valid_mask;
   assign a_ok       = (req_vertex_a != '0) && (req_vertex_a <= active_n);
   assign b_ok       = (req_vertex_b != '0) && (req_vertex_b <= active_n);

   always_comb begin
      state_in       = state_ff;
      k_in           = k_ff;
      u_in           = u_ff;
      listed_in      = listed_ff;
      comp_in        = comp_ff;
      rsp_valid_in   = 1'b0;
      rsp_number_in  = rsp_number_ff;
      rsp_mask_in    = rsp_mask_ff;
      rsp_last_in    = rsp_last_ff;
      cmd.op         = CELL_HOLD;
      cmd.pivot_idx  = ROW_IDX_W'(k_ff);
      cmd.a_idx      = ROW_IDX_W'(req_vertex_a - VC_W'(1));
      cmd.b_idx      = ROW_IDX_W'(req_vertex_b - VC_W'(1));
      cmd.valid_mask = valid_mask;
      busy           = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_action) begin
                  cmd.op    = CELL_PREP;
                  k_in      = '0;
                  u_in      = '0;
                  listed_in = '0;
                  comp_in   = '0;
                  state_in  = ST_CLOSE;
               end else if (a_ok && b_ok) begin
                  cmd.op = CELL_EDGE;
               end
            end
         end
         ST_CLOSE: begin
            cmd.op = CELL_ROUND;
            k_in   = k_ff + K_W'(1);
            if (k_ff == K_LAST) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (active_n == '0) begin
               cmd.op   = CELL_CLEAR;
               state_in = ST_IDLE;
            end else begin
               if (!listed_ff[u_ff]) begin
                  listed_in     = listed_ff | members;
                  comp_in       = comp_ff + VC_W'(1);
                  rsp_valid_in  = 1'b1;
                  rsp_number_in = comp_ff + VC_W'(1);
                  rsp_mask_in   = members;
                  rsp_last_in   = ((listed_ff | members) & valid_mask) == valid_mask;
               end
               u_in = u_ff + ROW_IDX_W'(1);
               if (VC_W'(u_ff) == active_n - VC_W'(1)) begin
                  cmd.op   = CELL_CLEAR;
                  state_in = ST_IDLE;
               end else begin
                  cmd.op = CELL_SHIFT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         u_ff         <= '0;
         listed_ff    <= '0;
         comp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         u_ff         <= u_in;
         listed_ff    <= listed_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_number_ff <= rsp_number_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_component_number = rsp_number_ff;
   assign rsp_member_mask      = rsp_mask_ff;
   assign rsp_last_component   = rsp_last_ff;

endmodule

// File: rtl/graph_components_by_closure.sv
// top level: connected components of an undirected graph by boolean closure
//
// usage: each transaction on the request side is taken when start is high and
// busy is low. req_action low adds the edge req_vertex_a - req_vertex_b;
// edges with an endpoint of 0 or above the vertex count in use are dropped.
// req_action high finishes the graph: the adjacency rows circulate once around
// a ring of R = min(MAX_VERTICES, 32) row cells, one closure round per cycle
// with the head row as pivot, then circulate again for the component scan.
// busy stays high after a finish until the scan is done. each component
// comes out as one rsp_valid pulse carrying its number, member mask and a
// last flag, in the cycle after its scan step; results cannot be held off.
// after the scan all rows are cleared; the marks are cleared at the next finish.
// csr_wr_en writes the vertex count; write it only while the block is idle.
// reset clears all rows and marks and sets the vertex count to 32.
module graph_components_by_closure
   import gcbc_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_action,
   input  logic [VC_W-1:0]      req_vertex_a,
   input  logic [VC_W-1:0]      req_vertex_b,
   input  logic                 csr_wr_en,
   input  logic [VC_W-1:0]      csr_wr_data,
   output logic                 rsp_valid,
   output logic [VC_W-1:0]      rsp_component_number,
   output logic [ROW_BITS-1:0]  rsp_member_mask,
   output logic                 rsp_last_component
);

   localparam int ROWS = (MAX_VERTICES < ROW_LIMIT) ? MAX_VERTICES : ROW_LIMIT;
   localparam logic [VC_W-1:0] ROWS_V = VC_W'(ROWS);

   logic [VC_W-1:0]      vertex_count_ff, vertex_count_in;
   logic [VC_W-1:0]      active_n;
   cell_cmd_type         cmd;
   logic [ROW_BITS-1:0]  rows [ROWS];

   assign vertex_count_in = csr_wr_en ? csr_wr_data : vertex_count_ff;
   assign active_n        = (vertex_count_ff > ROWS_V) ? ROWS_V : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RST;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   gcbc_ctrl #(
      .CELL_COUNT (ROWS)
   ) u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .req_action           (req_action),
      .req_vertex_a         (req_vertex_a),
      .req_vertex_b         (req_vertex_b),
      .active_n             (active_n),
      .head_row             (rows[0]),
      .busy                 (busy),
      .cmd                  (cmd),
      .rsp_valid            (rsp_valid),
      .rsp_component_number (rsp_component_number),
      .rsp_member_mask      (rsp_member_mask),
      .rsp_last_component   (rsp_last_component)
   );

   for (genvar i = 0; i < ROWS; i++) begin : g_cell
      gcbc_cell #(
         .ROW_INDEX (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .pivot_row    (rows[0]),
         .neighbor_row (rows[(i + 1) % ROWS]),
         .row          (rows[i])
      );
   end

endmodule

// File: dv/tb_top.sv
// testbench for the connected components by closure block
`timescale 1ns / 1ps

module tb_top
   import gcbc_pkg::*;
();

   localparam logic ACT_LINK      = 1'b0;
   localparam logic ACT_FINISH    = 1'b1;
   localparam int   ITEM_TARGET   = 360;
   localparam int   SETTLE_CYCLES = 80;

   typedef struct {
      logic [VC_W-1:0]     number;
      logic [ROW_BITS-1:0] members;
      logic                last;
   } component_type;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                start        = 1'b0;
   logic                req_action   = 1'b0;
   logic [VC_W-1:0]     req_vertex_a = '0;
   logic [VC_W-1:0]     req_vertex_b = '0;
   logic                csr_wr_en    = 1'b0;
   logic [VC_W-1:0]     csr_wr_data  = '0;
   logic                busy;
   logic                rsp_valid;
   logic [VC_W-1:0]     rsp_component_number;
   logic [ROW_BITS-1:0] rsp_member_mask;
   logic                rsp_last_component;

   // predictor state
   logic [ROW_BITS-1:0] adj_rows [ROW_LIMIT];
   logic [ROW_BITS-1:0] listed_vertices;
   logic [VC_W-1:0]     vertex_count;
   component_type       expected_components [$];

   int errors        = 0;
   int items_counted = 0;
   bit idle_on       = 1'b1;

   always #5 clock = ~clock;

   graph_components_by_closure dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_action           (req_action),
      .req_vertex_a         (req_vertex_a),
      .req_vertex_b         (req_vertex_b),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .rsp_valid            (rsp_valid),
      .rsp_component_number (rsp_component_number),
      .rsp_member_mask      (rsp_member_mask),
      .rsp_last_component   (rsp_last_component)
   );

   function automatic int active_vertices();
      int n;
      n = vertex_count;
      if (n > MAX_VERTICES_DEF) n = MAX_VERTICES_DEF;
      if (n > ROW_LIMIT) n = ROW_LIMIT;
      return n;
   endfunction

   function automatic bit link_in_range(input logic [VC_W-1:0] a, b);
      int n;
      n = active_vertices();
      return a >= 1 && a <= n && b >= 1 && b <= n;
   endfunction

   function automatic void clear_graph();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      listed_vertices = '0;
   endfunction

   // loads a link, or closes the graph and lists its components
   task automatic predict_item(input logic act, input logic [VC_W-1:0] a, b);
      int n;
      logic [ROW_BITS-1:0] valid;
      component_type comp;
      n = active_vertices();
      valid = '0;
      for (int v = 0; v < n; v++) valid[v] = 1'b1;
      if (act == ACT_LINK) begin
         if (link_in_range(a, b)) begin
            adj_rows[a - 1][b - 1] = 1'b1;
            adj_rows[b - 1][a - 1] = 1'b1;
         end
      end else begin
         for (int u = 0; u < n; u++) begin
            adj_rows[u] = adj_rows[u] & valid;
            adj_rows[u][u] = 1'b1;
         end
         for (int k = 0; k < n; k++)
            for (int u = 0; u < n; u++)
               if (adj_rows[u][k]) adj_rows[u] = adj_rows[u] | adj_rows[k];
         comp.number = '0;
         for (int u = 0; u < n; u++) begin
            if (!listed_vertices[u]) begin
               comp.number  = comp.number + 1'b1;
               comp.members = adj_rows[u] & valid;
               comp.last    = 1'b0;
               listed_vertices = listed_vertices | comp.members;
               expected_components.push_back(comp);
            end
         end
         if (comp.number != 0)
            expected_components[expected_components.size() - 1].last = 1'b1;
         clear_graph();
      end
   endtask

   task automatic send_item(input logic act, input logic [VC_W-1:0] a, b);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 10) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start        <= 1'b1;
      req_action   <= act;
      req_vertex_a <= a;
      req_vertex_b <= b;
      do @(posedge clock); while (busy);
      items_counted++;
      predict_item(act, a, b);
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      start <= 1'b0;
      while (expected_components.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_vertex_count(input logic [VC_W-1:0] value);
      wait_all_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      vertex_count = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic void check_field(input string name,
                                       input logic [ROW_BITS-1:0] want, got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      component_type want;
      if (!reset && rsp_valid) begin
         if (expected_components.size() == 0) begin
            $display("%0t: unexpected transaction, number %0d mask %h last %0d",
                     $time, rsp_component_number, rsp_member_mask, rsp_last_component);
            errors++;
         end else begin
            want = expected_components.pop_front();
            check_field("component_number", ROW_BITS'(want.number),
                        ROW_BITS'(rsp_component_number));
            check_field("member_mask", want.members, rsp_member_mask);
            check_field("last_component", ROW_BITS'(want.last),
                        ROW_BITS'(rsp_last_component));
         end
      end
   end

   // every vertex alone after reset
   task automatic test_empty_graph();
      send_item(ACT_FINISH, '0, '0);
   endtask

   task automatic test_extreme_links();
      send_item(ACT_LINK, 6'd1, 6'd32);
      send_item(ACT_LINK, 6'd32, 6'd1);
      send_item(ACT_LINK, 6'd1, 6'd1);
      send_item(ACT_LINK, 6'd5, 6'd6);
      send_item(ACT_LINK, 6'd6, 6'd7);
      send_item(ACT_FINISH, 6'd63, 6'd63);
   endtask

   task automatic test_ignored_links();
      send_item(ACT_LINK, 6'd0, 6'd5);
      send_item(ACT_LINK, 6'd5, 6'd0);
      send_item(ACT_LINK, 6'd33, 6'd2);
      send_item(ACT_LINK, 6'd63, 6'd63);
      send_item(ACT_LINK, 6'd2, 6'd40);
      send_item(ACT_LINK, 6'd2, 6'd3);
      send_item(ACT_FINISH, 6'd0, 6'd0);
   endtask

   task automatic test_count_limits();
      write_vertex_count(6'd1);
      send_item(ACT_LINK, 6'd1, 6'd2);
      send_item(ACT_LINK, 6'd1, 6'd1);
      send_item(ACT_FINISH, 6'd0, 6'd0);
      write_vertex_count(6'd0);
      send_item(ACT_FINISH, 6'd0, 6'd0);
      write_vertex_count(6'd63);
      send_item(ACT_LINK, 6'd32, 6'd31);
      send_item(ACT_FINISH, 6'd0, 6'd0);
   endtask

   // links loaded above the count must be dropped on finish
   task automatic test_count_lowered();
      write_vertex_count(6'd32);
      send_item(ACT_LINK, 6'd3, 6'd20);
      send_item(ACT_LINK, 6'd2, 6'd3);
      write_vertex_count(6'd8);
      send_item(ACT_FINISH, 6'd0, 6'd0);
   endtask

   task automatic test_random_graphs();
      int phase;
      int pick;
      int eff;
      int graphs;
      int links;
      logic [VC_W-1:0] a, b;
      phase = 0;
      while (items_counted < ITEM_TARGET) begin
         idle_on = (phase != 2);
         pick = $urandom_range(99);
         if (pick < 10) write_vertex_count(6'd1);
         else if (pick < 22) write_vertex_count(6'd32);
         else if (pick < 27) write_vertex_count(6'd2);
         else if (pick < 30) write_vertex_count(6'd0);
         else if (pick < 35) write_vertex_count(6'($urandom_range(33, 63)));
         else write_vertex_count(6'($urandom_range(3, 31)));
         eff = active_vertices();
         graphs = (phase == 2) ? 6 : $urandom_range(1, 4);
         repeat (graphs) begin
            links = $urandom_range(0, eff + eff / 2 + 1);
            repeat (links) begin
               if (eff == 0 || $urandom_range(99) < 15) begin
                  a = 6'($urandom_range(0, 63));
                  b = 6'($urandom_range(0, 63));
               end else begin
                  a = 6'($urandom_range(1, eff));
                  b = 6'($urandom_range(1, eff));
               end
               send_item(ACT_LINK, a, b);
            end
            // sometimes no finish, so the links carry into the next graph
            if ($urandom_range(99) >= 10) begin
               if ($urandom_range(99) < 15) wait_all_results();
               send_item(ACT_FINISH, 6'($urandom), 6'($urandom));
            end
         end
         phase++;
      end
      idle_on = 1'b1;
   endtask

   initial begin
      clear_graph();
      vertex_count = VERTEX_COUNT_RST;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_graph();
      test_extreme_links();
      test_ignored_links();
      test_count_limits();
      test_count_lowered();
      test_random_graphs();
      wait_all_results();
      if (errors == 0 && expected_components.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
